### hw/rtl/upwind_speed_scaled_gradient_core_defines.svh
// assertion macros shared by the upwind gradient core
`ifndef UPWIND_SPEED_SCALED_GRADIENT_CORE_DEFINES_SVH
`define UPWIND_SPEED_SCALED_GRADIENT_CORE_DEFINES_SVH

// same-cycle implication
`define USSG_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ussg: implication check failed");

// next-cycle implication
`define USSG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ussg: next-cycle check failed");

`endif

### hw/rtl/ussg_pkg.sv
// shared constants for the upwind speed-scaled gradient core
package ussg_pkg;

  localparam int PIXEL_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 25;
  localparam int FRAC_BITS       = 8;
  localparam int ROOT_CAP_LOG2   = 32;
  localparam int ROOT_WIDTH_DEF  = PIXEL_WIDTH_DEF + 2;

endpackage

### hw/rtl/upwind_speed_scaled_gradient_core.sv
// top level: upwind gradient magnitude scaled by front speed, one pixel per clock
//
// Takes one pixel stencil per clock whenever start is high; busy is always low because
// the datapath is a fixed pipeline with no stall. Each transaction produces one result,
// shown on result with done high for exactly one cycle. Depth is set by the square root,
// which resolves one root bit per stage (PIXEL_WIDTH + 2 stages), plus four stages of
// differences, squares and sums, one multiply stage and one saturation stage. Results
// leave in acceptance order and must be captured in the cycle done is high.
`include "upwind_speed_scaled_gradient_core_defines.svh"

module upwind_speed_scaled_gradient_core #(
  parameter int PIXEL_WIDTH = ussg_pkg::PIXEL_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [PIXEL_WIDTH-1:0]         center,
  input  logic signed [PIXEL_WIDTH-1:0]         up,
  input  logic signed [PIXEL_WIDTH-1:0]         down,
  input  logic signed [PIXEL_WIDTH-1:0]         left,
  input  logic signed [PIXEL_WIDTH-1:0]         right,
  input  logic signed [PIXEL_WIDTH-1:0]         speed,
  input  logic                                  on_border,
  output logic                                  done,
  output logic signed [ussg_pkg::OUT_WIDTH-1:0] result
);
  import ussg_pkg::*;

  localparam int P    = PIXEL_WIDTH;
  localparam int DW   = P + 1;           // difference
  localparam int MW   = P + 1;           // kept magnitude, up to 2^P - 1
  localparam int SQW  = 2 * P + 1;       // square
  localparam int RW   = P + 2;           // root bits
  localparam int RDW  = 2 * RW;          // radicand
  localparam int TW   = 2 * P + 1;       // {border, speed, |speed|}
  localparam int CW   = (RW > ROOT_CAP_LOG2 + 1) ? RW : ROOT_CAP_LOG2 + 1;
  localparam int PW   = P + CW;          // product
  localparam int EW   = (P > OUT_WIDTH) ? P : OUT_WIDTH;
  localparam int LAT  = RW + 6;

  localparam logic [CW-1:0] ROOT_CAP = CW'(1) << ROOT_CAP_LOG2;
  localparam logic [PW-FRAC_BITS-1:0] QPOS_MAX =
    (PW-FRAC_BITS)'((1 << (OUT_WIDTH - 1)) - 1);
  localparam logic [PW-FRAC_BITS:0] QNEG_MAX = (PW-FRAC_BITS+1)'(1 << (OUT_WIDTH - 1));
  localparam logic [PW:0] RND = (PW+1)'((1 << FRAC_BITS) - 1);
  localparam logic signed [EW-1:0] OUT_MAX = EW'((1 << (OUT_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] OUT_MIN = ~OUT_MAX;

  function automatic logic [MW-1:0] keep_part(input logic signed [DW-1:0] v,
                                              input logic neg_side);
    logic [MW-1:0] m;
    if (neg_side) begin
      m = (v < 0) ? MW'(-v) : '0;
    end else begin
      m = (v > 0) ? MW'(v) : '0;
    end
    return m;
  endfunction

  assign busy = 1'b0;

  // stage 1: differences and upwind selection
  logic signed [DW-1:0] dif [4];
  logic                 spd_pos;
  logic [P-1:0]         spd_mag;

  assign dif[0]  = DW'(center) - DW'(up);
  assign dif[1]  = DW'(down)   - DW'(center);
  assign dif[2]  = DW'(center) - DW'(left);
  assign dif[3]  = DW'(right)  - DW'(center);
  assign spd_pos = (speed > 0);
  assign spd_mag = speed[P-1] ? P'(-speed) : P'(speed);

  logic                 s1_vld, s2_vld, s3_vld, s4_vld;
  logic                 s1_bdr, s2_bdr, s3_bdr, s4_bdr;
  logic signed [P-1:0]  s1_spd, s2_spd, s3_spd, s4_spd;
  logic [P-1:0]         s1_smag, s2_smag, s3_smag, s4_smag;
  logic [MW-1:0]        s1_mag [4];
  logic [SQW-1:0]       s2_sq  [4];
  logic [SQW:0]         s3_col, s3_row;
  logic [RDW-1:0]       s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      s1_vld <= start;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    // backward differences keep the negative part for positive speed
    s1_mag[0] <= keep_part(dif[0], spd_pos);
    s1_mag[1] <= keep_part(dif[1], !spd_pos);
    s1_mag[2] <= keep_part(dif[2], spd_pos);
    s1_mag[3] <= keep_part(dif[3], !spd_pos);
    s1_bdr    <= on_border;
    s1_spd    <= speed;
    s1_smag   <= spd_mag;

    for (int k = 0; k < 4; k++) begin
      s2_sq[k] <= s1_mag[k] * s1_mag[k];
    end
    s2_bdr  <= s1_bdr;
    s2_spd  <= s1_spd;
    s2_smag <= s1_smag;

    s3_col  <= (SQW+1)'(s2_sq[0]) + (SQW+1)'(s2_sq[1]);
    s3_row  <= (SQW+1)'(s2_sq[2]) + (SQW+1)'(s2_sq[3]);
    s3_bdr  <= s2_bdr;
    s3_spd  <= s2_spd;
    s3_smag <= s2_smag;

    s4_sum  <= RDW'(s3_col) + RDW'(s3_row);
    s4_bdr  <= s3_bdr;
    s4_spd  <= s3_spd;
    s4_smag <= s3_smag;
  end

  // square root pipeline
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  logic [TW-1:0] sq_tag;

  ussg_isqrt #(
    .RW    (RW),
    .TAG_W (TW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s4_vld),
    .radicand (s4_sum),
    .in_tag   ({s4_bdr, s4_spd, s4_smag}),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_tag  (sq_tag)
  );

  // multiply stage
  logic                t_bdr;
  logic signed [P-1:0] t_spd;
  logic [P-1:0]        t_smag;
  logic [CW-1:0]       root_ext;
  logic [CW-1:0]       root_cap;

  assign {t_bdr, t_spd, t_smag} = sq_tag;
  assign root_ext = CW'(sq_root);
  assign root_cap = (root_ext > ROOT_CAP) ? ROOT_CAP : root_ext;

  logic                m_vld;
  logic                m_bdr;
  logic signed [P-1:0] m_spd;
  logic [PW-1:0]       m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_prod <= t_smag * root_cap;
    m_bdr  <= t_bdr;
    m_spd  <= t_spd;
  end

  // output stage: scale back to Q.8 and saturate
  logic signed [OUT_WIDTH-1:0] result_next;

  always_comb begin
    logic [PW-FRAC_BITS-1:0] q_pos;
    logic [PW:0]             rnd_sum;
    logic [PW-FRAC_BITS:0]   q_neg;
    logic signed [EW-1:0]    spd_e;
    q_pos   = m_prod[PW-1:FRAC_BITS];
    rnd_sum = (PW+1)'(m_prod) + RND;
    q_neg   = rnd_sum[PW:FRAC_BITS];
    spd_e   = EW'(m_spd);
    if (m_bdr) begin
      if (spd_e > OUT_MAX) begin
        result_next = OUT_WIDTH'(OUT_MAX);
      end else if (spd_e < OUT_MIN) begin
        result_next = OUT_WIDTH'(OUT_MIN);
      end else begin
        result_next = OUT_WIDTH'(spd_e);
      end
    end else if (!m_spd[P-1]) begin
      result_next = (q_pos > QPOS_MAX) ? OUT_WIDTH'(QPOS_MAX) : OUT_WIDTH'(q_pos);
    end else begin
      // negative speed rounds the magnitude up so the shift floors toward minus infinity
      result_next = (q_neg > QNEG_MAX) ? -OUT_WIDTH'(QNEG_MAX) : -OUT_WIDTH'(q_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // checks
  `USSG_ASSERT_IMPL(a_latency, clk, rst, 1'b1, done == $past(start && !rst, LAT))
  `USSG_ASSERT_IMPL(a_sign, clk, rst, done && result[OUT_WIDTH-1], $past(speed[P-1], LAT))
  `USSG_ASSERT_IMPL(a_zero_speed, clk, rst, done && $past(speed == '0, LAT), result == '0)
  `USSG_ASSERT_NEXT(a_zero_prod, clk, rst, m_vld && !m_bdr && m_prod == '0, result == '0)

endmodule

### hw/rtl/ussg_isqrt.sv
// pipelined floor square root, one root bit per register stage
module ussg_isqrt #(
  parameter int RW    = ussg_pkg::ROOT_WIDTH_DEF,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [2*RW-1:0]   radicand,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_vld,
  output logic [RW-1:0]     root,
  output logic [TAG_W-1:0]  out_tag
);
  import ussg_pkg::*;

  logic              vld_q  [RW];
  logic [RW:0]       rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [2*RW-1:0]   rad_q  [RW];
  logic [TAG_W-1:0]  tag_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic              vld_in;
    logic [RW:0]       rem_in;
    logic [RW-1:0]     root_in;
    logic [2*RW-1:0]   rad_in;
    logic [TAG_W-1:0]  tag_in;
    logic [RW+2:0]     rem_sh;
    logic [RW+2:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign tag_in  = in_tag;
    end else begin : g_rest
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign tag_in  = tag_q[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i]  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
      root_q[i] <= {root_in[RW-2:0], ge};
      rad_q[i]  <= {rad_in[2*RW-3:0], 2'b00};
      tag_q[i]  <= tag_in;
    end
  end

  assign out_vld = vld_q[RW-1];
  assign root    = root_q[RW-1];
  assign out_tag = tag_q[RW-1];

endmodule
